/* design/csd_pkg.sv */
// ----------------------------------------------------------------------------
// csd_pkg: shared types and codes for the client/server dispatcher
// Request and result payload structs, event codes and register reset value.
// ----------------------------------------------------------------------------
package csd_pkg;

    // request kinds
    localparam logic REQ_CLIENT = 1'b0;
    localparam logic REQ_SERVER = 1'b1;

    // result event codes
    localparam logic [1:0] EV_ASSIGNED = 2'd0;
    localparam logic [1:0] EV_WAITS    = 2'd1;
    localparam logic [1:0] EV_DROPPED  = 2'd2;
    localparam logic [1:0] EV_IDLE     = 2'd3;

    localparam logic [4:0]  SEATS_RESET = 5'd4;
    localparam logic [15:0] DROP_MAX    = 16'hFFFF;

    typedef struct packed {
        logic       req_type;
        logic [7:0] client_id;
        logic [2:0] server_id;
    } req_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  client;
        logic [2:0]  server;
        logic [4:0]  free_seats;
        logic [15:0] drop_count;
    } rsp_t;

endpackage

/* design/client_server_dispatcher.sv */
// ----------------------------------------------------------------------------
// client_server_dispatcher: pairs arriving clients with free servers
// Idle servers and waiting clients live in two RAM-backed FIFOs.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_data carry one request: a client arriving
//   (client_id) or a server reporting free (server_id). rsp_valid/rsp_stall/
//   rsp_data return exactly one result per request: the event, the client
//   and server involved, the free waiting seats and the saturating drop count.
//   seats_we/seats_wdata write the number of waiting seats (reset 4); write
//   it only while no request is in flight.
// Timing:
//   A request is accepted while the controller is idle, and both FIFO RAMs
//   read their head entries on that edge. In the execute state, once the
//   output register is free, the head data is used, the FIFOs are pushed or
//   popped and the result is loaded into the output register. No new request
//   is taken until the last one has executed, since the RAM read comes
//   before each read-modify-write; rsp_valid rises once the result is loaded.
//   The write-back lands before the next read, so no forwarding.
// Reset and stall:
//   Reset empties both FIFOs (counts to zero, RAM contents untouched), clears
//   the drop count and restores 4 seats. While the result is stalled, the
//   next request is still taken and held until the output register frees.
// ----------------------------------------------------------------------------
module client_server_dispatcher #(
    parameter int NUM_SERVERS = 8,
    parameter int WAIT_DEPTH  = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  csd_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output csd_pkg::rsp_t rsp_data,
    input  logic          seats_we,
    input  logic [4:0]    seats_wdata
);

    import csd_pkg::*;

    // address and count widths
    localparam int SRV_AW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int SRV_CW = $clog2(NUM_SERVERS + 1);
    localparam int WT_AW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WT_CW  = $clog2(WAIT_DEPTH + 1);
    localparam int LIM_W  = (WT_CW > 5) ? WT_CW : 5;

    // controller states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic              state_reg, state_next;
    req_t              req_reg;
    logic [4:0]        seats_reg;
    logic [SRV_AW-1:0] idle_head_reg, idle_head_next;
    logic [SRV_CW-1:0] idle_cnt_reg, idle_cnt_next;
    logic [WT_AW-1:0]  wait_head_reg, wait_head_next;
    logic [WT_CW-1:0]  wait_cnt_reg, wait_cnt_next;
    logic [15:0]       drop_reg, drop_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    logic              accept;
    logic              fire;

    // RAM ports
    logic              idle_we;
    logic [SRV_AW-1:0] idle_waddr;
    logic [2:0]        idle_rdata;
    logic              wait_we;
    logic [WT_AW-1:0]  wait_waddr;
    logic [7:0]        wait_rdata;

    // tail and limit helpers
    logic [SRV_AW:0]   idle_sum;
    logic [WT_AW:0]    wait_sum;
    logic [LIM_W-1:0]  seat_lim;
    logic [LIM_W-1:0]  wait_cnt_ext;
    logic              sid_bad;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg == ST_EXEC);
    assign fire      = (state_reg == ST_EXEC) && (!out_valid_reg || !rsp_stall);
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    // both FIFOs read their head when a request is taken
    csd_ram #(
        .WIDTH (3),
        .DEPTH (NUM_SERVERS)
    ) u_idle_ram (
        .clk   (clk),
        .we    (idle_we),
        .waddr (idle_waddr),
        .wdata (req_reg.server_id),
        .re    (accept),
        .raddr (idle_head_reg),
        .rdata (idle_rdata)
    );

    csd_ram #(
        .WIDTH (8),
        .DEPTH (WAIT_DEPTH)
    ) u_wait_ram (
        .clk   (clk),
        .we    (wait_we),
        .waddr (wait_waddr),
        .wdata (req_reg.client_id),
        .re    (accept),
        .raddr (wait_head_reg),
        .rdata (wait_rdata)
    );

    // tail = (head + count) mod depth; count stays below depth on a push
    assign idle_sum   = (SRV_AW + 1)'(idle_head_reg) + (SRV_AW + 1)'(idle_cnt_reg);
    assign idle_waddr = (idle_sum >= (SRV_AW + 1)'(NUM_SERVERS))
                        ? SRV_AW'(idle_sum - (SRV_AW + 1)'(NUM_SERVERS))
                        : SRV_AW'(idle_sum);
    assign wait_sum   = (WT_AW + 1)'(wait_head_reg) + (WT_AW + 1)'(wait_cnt_reg);
    assign wait_waddr = (wait_sum >= (WT_AW + 1)'(WAIT_DEPTH))
                        ? WT_AW'(wait_sum - (WT_AW + 1)'(WAIT_DEPTH))
                        : WT_AW'(wait_sum);

    // seats above the queue depth act as the depth
    assign seat_lim     = (LIM_W'(seats_reg) > LIM_W'(WAIT_DEPTH))
                          ? LIM_W'(WAIT_DEPTH) : LIM_W'(seats_reg);
    assign wait_cnt_ext = LIM_W'(wait_cnt_reg);
    assign sid_bad      = {29'd0, req_reg.server_id} >= 32'(NUM_SERVERS);

    always_comb
    begin
        logic [LIM_W-1:0] cnt_after;

        state_next     = state_reg;
        idle_head_next = idle_head_reg;
        idle_cnt_next  = idle_cnt_reg;
        wait_head_next = wait_head_reg;
        wait_cnt_next  = wait_cnt_reg;
        drop_next      = drop_reg;
        out_next       = out_reg;
        idle_we        = 1'b0;
        wait_we        = 1'b0;
        cnt_after      = '0;
        out_valid_next = (out_valid_reg && rsp_stall);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next          = ST_IDLE;
                    out_valid_next      = 1'b1;
                    out_next.client     = 8'd0;
                    out_next.server     = 3'd0;
                    if (req_reg.req_type == REQ_CLIENT)
                    begin
                        out_next.client = req_reg.client_id;
                        if (idle_cnt_reg != '0)
                        begin
                            // hand the client to the oldest idle server
                            out_next.server    = idle_rdata;
                            out_next.event_res = EV_ASSIGNED;
                            idle_cnt_next      = idle_cnt_reg - 1'b1;
                            idle_head_next     = (idle_head_reg == SRV_AW'(NUM_SERVERS - 1))
                                                 ? '0 : idle_head_reg + 1'b1;
                        end
                        else if (wait_cnt_ext < seat_lim)
                        begin
                            out_next.event_res = EV_WAITS;
                            wait_we            = 1'b1;
                            wait_cnt_next      = wait_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            out_next.event_res = EV_DROPPED;
                            if (drop_reg != DROP_MAX)
                            begin
                                drop_next = drop_reg + 16'd1;
                            end
                        end
                    end
                    else
                    begin
                        out_next.server    = req_reg.server_id;
                        out_next.event_res = EV_IDLE;
                        if (sid_bad)
                        begin
                            // unknown server: report and drop the request
                            out_next.event_res = EV_IDLE;
                        end
                        else if (wait_cnt_reg != '0)
                        begin
                            out_next.client    = wait_rdata;
                            out_next.event_res = EV_ASSIGNED;
                            wait_cnt_next      = wait_cnt_reg - 1'b1;
                            wait_head_next     = (wait_head_reg == WT_AW'(WAIT_DEPTH - 1))
                                                 ? '0 : wait_head_reg + 1'b1;
                        end
                        else if (idle_cnt_reg < SRV_CW'(NUM_SERVERS))
                        begin
                            idle_we       = 1'b1;
                            idle_cnt_next = idle_cnt_reg + 1'b1;
                        end
                    end
                    cnt_after           = LIM_W'(wait_cnt_next);
                    out_next.free_seats = (seat_lim > cnt_after)
                                          ? 5'(seat_lim - cnt_after) : 5'd0;
                    out_next.drop_count = drop_next;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seats_reg     <= SEATS_RESET;
            idle_head_reg <= '0;
            idle_cnt_reg  <= '0;
            wait_head_reg <= '0;
            wait_cnt_reg  <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idle_head_reg <= idle_head_next;
            idle_cnt_reg  <= idle_cnt_next;
            wait_head_reg <= wait_head_next;
            wait_cnt_reg  <= wait_cnt_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            if (seats_we)
            begin
                seats_reg <= seats_wdata;
            end
        end
    end

    // payload registers: hold the request and the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_data;
        end
        out_reg <= out_next;
    end

    // a client waits only while no server is idle, and the reverse
    a_not_both_queued: assert property (@(posedge clk) disable iff (!rst_n)
        !((idle_cnt_reg != '0) && (wait_cnt_reg != '0)))
        else $error("idle servers and waiting clients at once");

    a_idle_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idle_cnt_reg <= SRV_CW'(NUM_SERVERS))
        else $error("idle server count above server count");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted request not executed");

    a_drop_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (drop_reg >= $past(drop_reg)))
        else $error("drop count went down");

endmodule

/* design/csd_ram.sv */
// ----------------------------------------------------------------------------
// csd_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module csd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* verif/dispatch_scoreboard_pkg.sv */
// ----------------------------------------------------------------------------
// dispatch_scoreboard_pkg: result predictor and checker for the dispatcher
// Tracks the idle-server and waiting-client queues, the seat setting and the
// drop count, predicts one result per accepted request, and compares results.
// ----------------------------------------------------------------------------
package dispatch_scoreboard_pkg;

    import csd_pkg::*;

    localparam int NUM_SERVERS = 8;
    localparam int WAIT_DEPTH  = 16;
    localparam int MAX_REPORTS = 60;

    class dispatch_scoreboard;

        logic [4:0]  seats;
        logic [2:0]  idle_fifo [NUM_SERVERS];
        logic [2:0]  idle_head;
        logic [3:0]  idle_count;
        logic [7:0]  wait_fifo [WAIT_DEPTH];
        logic [3:0]  wait_head;
        logic [4:0]  wait_count;
        logic [15:0] drops;
        rsp_t        predicted_results [$];
        int          errors;

        function new();
            seats      = SEATS_RESET;
            idle_head  = '0;
            idle_count = '0;
            wait_head  = '0;
            wait_count = '0;
            drops      = '0;
            errors     = 0;
        endfunction

        function void set_seats(logic [4:0] value);
            seats = value;
        endfunction

        function int pending();
            return predicted_results.size();
        endfunction

        // Note one accepted request and queue the result it must produce.
        function void dispatch_request(req_t req);
            rsp_t       res;
            logic [4:0] limit;
            logic [2:0] idle_tail;
            logic [3:0] wait_tail;
            res   = '0;
            limit = (seats > 5'(WAIT_DEPTH)) ? 5'(WAIT_DEPTH) : seats;
            if (req.req_type == REQ_CLIENT) begin
                res.client = req.client_id;
                if (idle_count != 0) begin
                    res.server    = idle_fifo[idle_head];
                    idle_head     = idle_head + 3'd1;
                    idle_count    = idle_count - 4'd1;
                    res.event_res = EV_ASSIGNED;
                end else if (wait_count < limit) begin
                    wait_tail            = wait_head + wait_count[3:0];
                    wait_fifo[wait_tail] = req.client_id;
                    wait_count           = wait_count + 5'd1;
                    res.event_res        = EV_WAITS;
                end else begin
                    if (drops != DROP_MAX)
                        drops = drops + 16'd1;
                    res.event_res = EV_DROPPED;
                end
            end else begin
                res.server = req.server_id;
                if (wait_count != 0) begin
                    res.client    = wait_fifo[wait_head];
                    wait_head     = wait_head + 4'd1;
                    wait_count    = wait_count - 5'd1;
                    res.event_res = EV_ASSIGNED;
                end else begin
                    // a full idle queue drops the server but still reports idle
                    if (idle_count < 4'(NUM_SERVERS)) begin
                        idle_tail            = idle_head + idle_count[2:0];
                        idle_fifo[idle_tail] = req.server_id;
                        idle_count           = idle_count + 4'd1;
                    end
                    res.event_res = EV_IDLE;
                end
            end
            res.free_seats = (limit > wait_count) ? limit - wait_count : 5'd0;
            res.drop_count = drops;
            predicted_results.push_back(res);
        endfunction

        function void mismatch(string field, logic [15:0] want, logic [15:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $error("%s: expected %0d, actual %0d", field, want, got);
        endfunction

        function void check_result(rsp_t got);
            rsp_t res;
            if (predicted_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("result with no request pending: %h", got);
                return;
            end
            res = predicted_results.pop_front();
            if (got.event_res !== res.event_res)
                mismatch("event_res", 16'(res.event_res), 16'(got.event_res));
            if (got.client !== res.client)
                mismatch("client", 16'(res.client), 16'(got.client));
            if (got.server !== res.server)
                mismatch("server", 16'(res.server), 16'(got.server));
            if (got.free_seats !== res.free_seats)
                mismatch("free_seats", 16'(res.free_seats), 16'(got.free_seats));
            if (got.drop_count !== res.drop_count)
                mismatch("drop_count", res.drop_count, got.drop_count);
        endfunction

    endclass

endpackage

/* verif/client_server_dispatcher_test.sv */
// ----------------------------------------------------------------------------
// client_server_dispatcher_test: self-checking bench for the dispatcher
// Drives directed and bursty random requests through several seat settings
// and idle/stall mixes, predicts every result and checks it field by field.
// ----------------------------------------------------------------------------
module client_server_dispatcher_test;

    timeunit 1ns;
    timeprecision 1ps;

    import csd_pkg::*;
    import dispatch_scoreboard_pkg::*;

    localparam int  ITEMS_PER_PHASE = 330;
    localparam int  NUM_PHASES      = 5;
    localparam int  HOLD_OFF_CYCLES = 400;
    localparam real TIMEOUT_NS      = 5_000_000.0;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    req_t       req_data;
    logic       rsp_valid;
    logic       rsp_stall;
    rsp_t       rsp_data;
    logic       seats_we;
    logic [4:0] seats_wdata;

    dispatch_scoreboard sb = new();

    // receiver behavior, set by the main sequence
    int recv_stall_pct = 0;
    int hold_cycles    = 0;

    client_server_dispatcher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .seats_we    (seats_we),
        .seats_wdata (seats_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bound the run: anything still going at this point is hung.
    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    // Receiver: stall at random, or hold off for a counted stretch when asked.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                rsp_stall <= 1'b1;
                hold_cycles--;
            end else begin
                rsp_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Check each result on the edge where it is taken.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp_data);
    end

    // Offer one request at the falling edge, hold it until taken, then
    // idle the sender as set by gap. With no gap, valid stays high for the
    // next request.
    task automatic send_request(input logic kind, input logic [7:0] cid,
                                input logic [2:0] sid, input int gap);
        req_t req;
        req.req_type  = kind;
        req.client_id = cid;
        req.server_id = sid;
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= req;
        do
            @(posedge clk);
        while (req_stall);
        sb.dispatch_request(req);
        if (gap > 0) begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every predicted result has come back, then
    // let the pipeline settle.
    task automatic drain_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the seat register; only called with nothing in flight.
    task automatic write_seats(input logic [4:0] value);
        @(negedge clk);
        seats_we    <= 1'b1;
        seats_wdata <= value;
        @(posedge clk);
        sb.set_seats(value);
        @(negedge clk);
        seats_we <= 1'b0;
    endtask

    initial
    begin
        int         send_pct [NUM_PHASES];
        int         stall_pct [NUM_PHASES];
        logic [4:0] phase_seats [NUM_PHASES];
        int         gap;
        int         burst_left;
        int         client_pct;
        logic       kind;

        send_pct    = '{0, 83, 0, 24, 0};
        stall_pct   = '{0, 0, 83, 24, 0};
        phase_seats = '{5'd16, 5'd0, 5'd31, 5'd1, 5'($urandom_range(31))};

        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_data    = '0;
        seats_we    = 1'b0;
        seats_wdata = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: fill the four reset seats, then overflow one client.
        send_request(REQ_CLIENT, 8'h00, 3'd0, 0);
        send_request(REQ_CLIENT, 8'hFF, 3'd0, 0);
        send_request(REQ_CLIENT, 8'h55, 3'd0, 0);
        send_request(REQ_CLIENT, 8'hAA, 3'd0, 0);
        send_request(REQ_CLIENT, 8'h01, 3'd0, 0);
        // free servers take the oldest waiting clients
        send_request(REQ_SERVER, 8'h00, 3'd0, 0);
        send_request(REQ_SERVER, 8'h00, 3'd7, 0);
        drain_results();

        // Lower the seats below occupancy: no new client waits, free reads 0.
        write_seats(5'd1);
        send_request(REQ_CLIENT, 8'h80, 3'd0, 0);
        send_request(REQ_SERVER, 8'h00, 3'd5, 0);
        send_request(REQ_SERVER, 8'h00, 3'd2, 0);
        drain_results();

        // No seats at all: a client with no idle server is dropped.
        write_seats(5'd0);
        send_request(REQ_CLIENT, 8'h7F, 3'd0, 0);
        drain_results();

        // Seats above the queue depth; repeat a free report, overfill the
        // idle queue, then let clients take the oldest idle servers.
        write_seats(5'd31);
        send_request(REQ_SERVER, 8'h00, 3'd3, 0);
        send_request(REQ_SERVER, 8'h00, 3'd3, 0);
        send_request(REQ_SERVER, 8'h00, 3'd0, 0);
        send_request(REQ_SERVER, 8'h00, 3'd1, 0);
        send_request(REQ_SERVER, 8'h00, 3'd2, 0);
        send_request(REQ_SERVER, 8'h00, 3'd4, 0);
        send_request(REQ_SERVER, 8'h00, 3'd5, 0);
        send_request(REQ_SERVER, 8'h00, 3'd6, 0);
        send_request(REQ_SERVER, 8'h00, 3'd7, 0);
        send_request(REQ_CLIENT, 8'h3C, 3'd0, 0);
        send_request(REQ_CLIENT, 8'hC3, 3'd0, 0);
        drain_results();

        // Random phases: each with its own seat setting and idle/stall mix.
        // Requests come in bursts biased toward clients or servers, so that
        // both the waiting queue and the idle queue fill and empty.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_seats(phase_seats[p]);
            recv_stall_pct = stall_pct[p];
            // last phase: hold the receiver off while requests keep coming
            if (p == NUM_PHASES - 1)
                hold_cycles = HOLD_OFF_CYCLES;
            burst_left = 0;
            client_pct = 50;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(40, 4);
                    case ($urandom_range(2))
                        0: client_pct = 20;
                        1: client_pct = 50;
                        default: client_pct = 85;
                    endcase
                end
                burst_left--;
                kind = ($urandom_range(99) < client_pct) ? REQ_CLIENT : REQ_SERVER;
                gap  = 0;
                while (gap < 200 && $urandom_range(99) < send_pct[p])
                    gap++;
                send_request(kind, 8'($urandom_range(255)), 3'($urandom_range(7)), gap);
            end
            // pause the sender until every result is back
            drain_results();
        end

        if (sb.pending() != 0)
            $error("%0d predicted results never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
